### sv/lzss_pkg.sv
// Shared constants and codes for the LZSS stream decompressor.
package lzss_pkg;

    // Ring window geometry
    localparam int unsigned WINDOW_SIZE = 4096;
    localparam int unsigned MATCH_MIN   = 3;
    localparam int unsigned WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int unsigned PROD_W      = WIN_AW + 1;
    localparam int unsigned LEN_W       = 5;

    typedef logic [WIN_AW-1:0] t_ring_addr;
    typedef logic [PROD_W-1:0] t_prod_cnt;
    typedef logic [7:0]        t_byte;

    localparam t_ring_addr RING_START = WIN_AW'(WINDOW_SIZE - 15 - MATCH_MIN);
    localparam t_prod_cnt  WIN_FULL   = PROD_W'(WINDOW_SIZE);

    // Decode phase codes
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_REF2 = 2'd2;

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COPY_RD = 2'd1;
    localparam logic [1:0] ST_COPY_WR = 2'd2;

endpackage

### sv/lzss_ring.sv
// Ring window memory: one write port, one registered read port.
module lzss_ring (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  lzss_pkg::t_ring_addr i_waddr,
    input  lzss_pkg::t_byte      i_wdata,
    input  lzss_pkg::t_ring_addr i_raddr,
    output lzss_pkg::t_byte      o_rdata
);
    import lzss_pkg::*;

    t_byte r_mem [WINDOW_SIZE];
    t_byte r_rdata;

    // Write the emitted byte, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lzss_stream_decompressor.sv
// LZSS stream decompressor: flag/literal/reference decode over a 4 KiB ring.
// Flag and first reference beats only update the decode state; a literal shows on the output next cycle.
// A reference holds the input until its last byte is copied; each copied byte passes through
// a read state (ring read, distance check) and then a write state (emit and store in the ring).
// Output stalls stretch the copy cycle by cycle; the output register holds one result.
// Synchronous active-low reset clears the sequencer and decode state; the ring is not
// cleared, entries not yet written in this stream are masked by the produced count.
module lzss_stream_decompressor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lzss_pkg::t_byte  i_in_byte,
    input  logic             i_stream_end,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lzss_pkg::t_byte  o_out_byte,
    output logic             o_run_last,
    output logic             o_stream_done
);
    import lzss_pkg::*;

    // Control registers
    logic [1:0]        r_state,     n_state;
    logic [1:0]        r_phase,     n_phase;
    t_ring_addr        r_wpos,      n_wpos;
    t_prod_cnt         r_produced,  n_produced;
    logic [7:0]        r_flags,     n_flags;
    logic [3:0]        r_flags_left, n_flags_left;
    t_byte             r_first,     n_first;
    t_ring_addr        r_src,       n_src;
    logic [LEN_W-1:0]  r_cnt,       n_cnt;
    logic              r_last,      n_last;
    logic              r_hit,       n_hit;
    logic              r_out_valid, n_out_valid;
    t_byte             r_out_byte,  n_out_byte;
    logic              r_run_last,  n_run_last;
    logic              r_done,      n_done;

    // Ring port
    logic       ring_we;
    t_byte      ring_wdata;
    t_byte      ring_rdata;

    logic       in_acc;
    logic       out_free;
    t_ring_addr dist12;
    t_prod_cnt  ring_dist;
    logic [3:0] flags_left_dec;

    lzss_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wpos),
        .i_wdata (ring_wdata),
        .i_raddr (r_src),
        .o_rdata (ring_rdata)
    );

    // Output register frees up when empty or taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Distance unit: ring distance behind the write position
    assign dist12    = r_wpos - r_src;
    assign ring_dist = (dist12 == '0) ? WIN_FULL : {1'b0, dist12};

    assign flags_left_dec = (r_flags_left != '0) ? r_flags_left - 4'd1 : 4'd0;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_wpos       = r_wpos;
        n_produced   = r_produced;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_first      = r_first;
        n_src        = r_src;
        n_cnt        = r_cnt;
        n_last       = r_last;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_run_last   = r_run_last;
        n_done       = r_done;
        ring_we      = 1'b0;
        ring_wdata   = i_in_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (r_phase)
                        PH_ITEM: begin
                            if (r_flags[0]) begin
                                // Literal: emit and store in the ring
                                ring_we      = 1'b1;
                                ring_wdata   = i_in_byte;
                                n_out_valid  = 1'b1;
                                n_out_byte   = i_in_byte;
                                n_run_last   = 1'b1;
                                n_done       = i_stream_end;
                                n_wpos       = r_wpos + 1'b1;
                                if (r_produced < WIN_FULL) begin
                                    n_produced = r_produced + 1'b1;
                                end
                                n_flags      = r_flags >> 1;
                                n_flags_left = flags_left_dec;
                                n_phase      = (flags_left_dec != '0) ? PH_ITEM : PH_FLAG;
                            end else begin
                                n_first = i_in_byte;
                                n_phase = PH_REF2;
                            end
                        end
                        PH_REF2: begin
                            // Second reference byte: start the copy
                            n_src   = {i_in_byte[7:4], r_first};
                            n_cnt   = LEN_W'(i_in_byte[3:0]) + LEN_W'(MATCH_MIN - 1);
                            n_last  = i_stream_end;
                            n_state = ST_COPY_RD;
                        end
                        default: begin
                            n_flags      = i_in_byte;
                            n_flags_left = 4'd8;
                            n_phase      = PH_ITEM;
                        end
                    endcase
                    // Restart the stream after its last beat, unless a copy is pending
                    if (i_stream_end && r_phase != PH_REF2) begin
                        n_wpos       = RING_START;
                        n_produced   = '0;
                        n_flags      = '0;
                        n_flags_left = '0;
                        n_first      = '0;
                        n_phase      = PH_FLAG;
                    end
                end
            end
            ST_COPY_RD: begin
                // Read issued at r_src; decide whether the entry is written
                n_hit   = (ring_dist <= r_produced);
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (out_free) begin
                    ring_we     = 1'b1;
                    ring_wdata  = r_hit ? ring_rdata : 8'd0;
                    n_out_valid = 1'b1;
                    n_out_byte  = ring_wdata;
                    n_run_last  = (r_cnt == '0);
                    n_done      = (r_cnt == '0) && r_last;
                    n_wpos      = r_wpos + 1'b1;
                    if (r_produced < WIN_FULL) begin
                        n_produced = r_produced + 1'b1;
                    end
                    n_src = r_src + 1'b1;
                    if (r_cnt == '0) begin
                        n_flags      = r_flags >> 1;
                        n_flags_left = flags_left_dec;
                        n_phase      = (flags_left_dec != '0) ? PH_ITEM : PH_FLAG;
                        n_state      = ST_IDLE;
                        if (r_last) begin
                            n_wpos       = RING_START;
                            n_produced   = '0;
                            n_flags      = '0;
                            n_flags_left = '0;
                            n_first      = '0;
                            n_phase      = PH_FLAG;
                        end
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = ST_COPY_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_FLAG;
            r_wpos       <= RING_START;
            r_produced   <= '0;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_first      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_wpos       <= n_wpos;
            r_produced   <= n_produced;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_first      <= n_first;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and copy registers
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_cnt      <= n_cnt;
        r_last     <= n_last;
        r_hit      <= n_hit;
        r_out_byte <= n_out_byte;
        r_run_last <= n_run_last;
        r_done     <= n_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_stream_done = r_done;

endmodule

### verif/lzss_stream_decompressor_checker.sv
// Checker for the LZSS stream decompressor: tracks input beats, predicts output beats, compares.
module lzss_stream_decompressor_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  lzss_pkg::t_byte  i_in_byte,
    input  logic             i_stream_end,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  lzss_pkg::t_byte  i_out_byte,
    input  logic             i_run_last,
    input  logic             i_stream_done,
    output int               o_error_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  run_last;
        logic  stream_done;
    } t_out_beat;

    // Decoder copy: window, write pointer, fill level and flag/phase tracking
    t_byte      win_mem [WINDOW_SIZE];
    t_ring_addr wr_pos;
    t_prod_cnt  emitted;
    t_byte      flag_bits;
    logic [3:0] flags_rem;
    t_byte      ref_lo;
    logic [1:0] phase;

    t_out_beat  expected_q [$];
    t_out_beat  copy_burst [$];
    t_out_beat  got;
    t_out_beat  want;
    int         error_total = 0;

    // Return the decode state to the start of a stream
    task automatic restart_stream();
        wr_pos    = RING_START;
        emitted   = '0;
        flag_bits = '0;
        flags_rem = '0;
        ref_lo    = '0;
        phase     = PH_FLAG;
    endtask

    // Emit one decoded byte and record it in the window
    task automatic emit_byte(input t_byte v);
        copy_burst.push_back({v, 1'b0, 1'b0});
        win_mem[wr_pos] = v;
        wr_pos = wr_pos + 1'b1;
        if (emitted < WIN_FULL) emitted = emitted + 1'b1;
    endtask

    // Drop the flag just used; fetch a new flag byte once all eight are gone
    task automatic consume_flag();
        flag_bits = flag_bits >> 1;
        if (flags_rem != 0) flags_rem = flags_rem - 1'b1;
        phase = (flags_rem != 0) ? PH_ITEM : PH_FLAG;
    endtask

    // Decode one input beat and queue the bytes it produces
    task automatic decode_beat(input t_byte data, input logic end_mark);
        t_ring_addr  base;
        t_ring_addr  src;
        t_ring_addr  gap;
        t_prod_cnt   back_dist;
        int unsigned run_len;
        copy_burst.delete();
        case (phase)
            PH_ITEM: begin
                if (flag_bits[0]) begin
                    emit_byte(data);
                    consume_flag();
                end else begin
                    ref_lo = data;
                    phase  = PH_REF2;
                end
            end
            PH_REF2: begin
                base    = {data[7:4], ref_lo};
                run_len = data[3:0] + MATCH_MIN;
                for (int i = 0; i < run_len; i++) begin
                    src       = base + t_ring_addr'(i);
                    gap       = wr_pos - src;
                    back_dist = t_prod_cnt'(gap);
                    // a copy from the write pointer itself reaches a full window back
                    if (back_dist == 0) back_dist = WIN_FULL;
                    // entries not yet written in this stream read as zero
                    emit_byte((back_dist <= emitted) ? win_mem[src] : t_byte'(0));
                end
                consume_flag();
            end
            default: begin
                flag_bits = data;
                flags_rem = 4'd8;
                phase     = PH_ITEM;
            end
        endcase
        // mark the last byte of the burst, then hand the burst to the expected queue
        if (copy_burst.size() > 0) begin
            copy_burst[copy_burst.size()-1].run_last    = 1'b1;
            copy_burst[copy_burst.size()-1].stream_done = end_mark;
        end
        foreach (copy_burst[k]) expected_q.push_back(copy_burst[k]);
        if (end_mark) restart_stream();
    endtask

    // Check output beats first, since they stem from earlier input beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_stream();
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_byte, i_run_last, i_stream_done};
                if (expected_q.size() == 0) begin
                    error_total++;
                    $display("%0t: output beat with nothing expected: %s %02h %0b %0b",
                             $time, "byte/run_last/stream_done",
                             got.data, got.run_last, got.stream_done);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        error_total++;
                        $display("%0t: output mismatch: expected byte %02h run_last %0b %s %0b",
                                 $time, want.data, want.run_last, "stream_done",
                                 want.stream_done);
                        $display("%0t:                  got      byte %02h run_last %0b %s %0b",
                                 $time, got.data, got.run_last, "stream_done",
                                 got.stream_done);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_beat(i_in_byte, i_stream_end);
        end
        o_error_count <= error_total;
        o_pending     <= expected_q.size();
    end

endmodule

### verif/lzss_stream_decompressor_tb.sv
// Top-level testbench for the LZSS stream decompressor: stimulus, handshake pacing and verdict.
module lzss_stream_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_BEATS = 240;
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CALM_FROM    = 120;
    localparam int unsigned CALM_TO      = 170;
    localparam int unsigned DRAIN_CYCLES = 64;

    typedef struct packed {
        t_byte data;
        logic  end_mark;
    } t_in_beat;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    t_byte in_byte     = '0;
    logic  stream_end  = 1'b0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    t_byte out_byte;
    logic  run_last;
    logic  stream_done;

    int          errors;
    int          pending;
    int unsigned cycle_cnt = 0;
    int unsigned beats_in  = 0;
    logic        in_fire   = 1'b0;
    logic        calm;

    t_in_beat    beat_q [$];
    t_ring_addr  gen_wp;
    int unsigned gen_made;

    lzss_stream_decompressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_byte     (in_byte),
        .i_stream_end  (stream_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_run_last    (run_last),
        .o_stream_done (stream_done)
    );

    lzss_stream_decompressor_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_byte     (in_byte),
        .i_stream_end  (stream_end),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_byte    (out_byte),
        .i_run_last    (run_last),
        .i_stream_done (stream_done),
        .o_error_count (errors),
        .o_pending     (pending)
    );

    // Both sides stop idling while this stretch of input beats goes by
    assign calm = (beats_in >= CALM_FROM) && (beats_in < CALM_TO);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Count cycles and register input acceptance for the driver
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_fire   <= in_valid && !in_stall;
        if (in_valid && !in_stall) beats_in <= beats_in + 1;
    end

    // Abort on a hung run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, one long hold-off so the block backs up into its input
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && beats_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic push_beat(input t_byte data, input logic end_mark);
        beat_q.push_back({data, end_mark});
    endtask

    // Queue a two-byte back reference and advance the tracked write pointer
    task automatic push_ref(input t_ring_addr pos, input logic [3:0] nib);
        push_beat(pos[7:0], 1'b0);
        push_beat({pos[11:8], nib}, 1'b0);
        gen_wp   = gen_wp + t_ring_addr'(nib + MATCH_MIN);
        gen_made = gen_made + nib + MATCH_MIN;
    endtask

    // Mostly copy recent history; sometimes the write pointer itself or anywhere at all
    function automatic t_ring_addr pick_ref_pos();
        int unsigned roll;
        int unsigned reach;
        roll  = $urandom_range(0, 99);
        reach = (gen_made > 300) ? 300 : gen_made;
        if (roll < 10 || reach == 0) return gen_wp;
        if (roll < 25) return t_ring_addr'($urandom);
        return gen_wp - t_ring_addr'($urandom_range(1, reach));
    endfunction

    // Well-formed stream with random content
    task automatic gen_stream();
        int unsigned groups;
        int unsigned g;
        int unsigned stop_at;
        bit          last_group;
        t_byte       flags;
        gen_wp   = RING_START;
        gen_made = 0;
        groups   = $urandom_range(1, 4);
        g        = 0;
        do begin
            g++;
            last_group = (g >= groups);
            stop_at    = last_group ? $urandom_range(1, 8) : 8;
            flags      = t_byte'($urandom);
            push_beat(flags, 1'b0);
            for (int k = 0; k < stop_at; k++) begin
                if (flags[k]) begin
                    push_beat(t_byte'($urandom), 1'b0);
                    gen_wp = gen_wp + 1'b1;
                    gen_made++;
                end else begin
                    push_ref(pick_ref_pos(), 4'($urandom));
                end
            end
        end while (!last_group);
        // close on the last beat, or on one more beat that may cut a reference short
        if ($urandom_range(0, 1)) beat_q[beat_q.size()-1].end_mark = 1'b1;
        else push_beat(t_byte'($urandom), 1'b1);
    endtask

    initial begin
        int unsigned sent;
        int unsigned directed_cnt;
        int unsigned noise_len;

        // Stream: two extreme literals, then six references
        push_beat(8'h03, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        // longest copy, overlapping the bytes it writes
        push_beat(8'hEE, 1'b0);
        push_beat(8'hFF, 1'b0);
        // copy from the write pointer before a full window is written
        push_beat(8'h02, 1'b0);
        push_beat(8'h00, 1'b0);
        // reaches back before stream start, partly zero filled
        push_beat(8'hE0, 1'b0);
        push_beat(8'hFF, 1'b0);
        // shortest copy, entirely unwritten
        push_beat(8'h00, 1'b0);
        push_beat(8'hF0, 1'b0);
        // read across the ring wrap
        push_beat(8'hF0, 1'b0);
        push_beat(8'hFF, 1'b0);
        // final reference closes the stream
        push_beat(8'h10, 1'b0);
        push_beat(8'h32, 1'b1);
        // flag byte that ends a stream
        push_beat(8'hA7, 1'b1);
        // reference cut off by the stream end
        push_beat(8'h01, 1'b0);
        push_beat(8'hA5, 1'b0);
        push_beat(8'h5A, 1'b1);
        // reference at stream start, then a literal that ends the stream
        push_beat(8'hFE, 1'b0);
        push_beat(8'hEE, 1'b0);
        push_beat(8'hF5, 1'b0);
        push_beat(8'h3C, 1'b1);
        directed_cnt = beat_q.size();

        // Random part: mostly well-formed streams, some noise bursts
        while (beat_q.size() < directed_cnt + RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 12) begin
                // noise: random bytes with stray stream ends, closed by a stream end
                noise_len = $urandom_range(1, 6);
                repeat (noise_len - 1) push_beat(t_byte'($urandom), $urandom_range(0, 7) == 0);
                push_beat(t_byte'($urandom), 1'b1);
            end else begin
                gen_stream();
            end
        end

        // Hold reset low, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender: hold a stalled beat, otherwise offer the next one or idle
        sent = 0;
        while (sent < beat_q.size()) begin
            @(negedge i_clk);
            if (in_fire) sent++;
            if (!(in_valid && !in_fire)) begin
                if (sent < beat_q.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid   <= 1'b1;
                    in_byte    <= beat_q[sent].data;
                    stream_end <= beat_q[sent].end_mark;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end

        // Drain outstanding results, then let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### lzss_stream_decompressor.f
sv/lzss_pkg.sv
sv/lzss_ring.sv
sv/lzss_stream_decompressor.sv
verif/lzss_stream_decompressor_checker.sv
verif/lzss_stream_decompressor_tb.sv
